### sv/pair_sum_index_finder_assert.svh
// Assertion macros for the pair sum index finder.
`ifndef PAIR_SUM_INDEX_FINDER_ASSERT_SVH
`define PAIR_SUM_INDEX_FINDER_ASSERT_SVH

`ifndef SYNTHESIS
`define PSIF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("psif assertion failed");
`define PSIF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psif implication failed");
`else
`define PSIF_ASSERT(lbl, prop)
`define PSIF_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

### sv/psif_pkg.sv
// Shared constants and types of the pair sum index finder.
package psif_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CMP_W           = DATA_W + 1;
  localparam int unsigned OUT_IDX_W       = 6;
  localparam int unsigned OUT_TDATA_W     = 16;
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  typedef enum logic [1:0] {
    STAT_STORED  = 2'd0,
    STAT_FOUND   = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic active;
    logic hit;
  } psif_tok_t;

  // Table write control broadcast to all cells.
  typedef struct packed {
    logic en;
    logic clr;
  } psif_wr_t;

endpackage

### sv/psif_cell.sv
// One table cell: holds one stored value and checks the passing search token.
module psif_cell import psif_pkg::*; #(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psif_tok_t           tok_i,
  input  logic [IDX_W-1:0]    partner_i,
  input  logic [CMP_W-1:0]    comp_i,
  input  psif_wr_t            wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  input  logic [DATA_W-1:0]   wr_data_i,
  output psif_tok_t           tok_o,
  output logic [IDX_W-1:0]    partner_o
);

  logic [DATA_W-1:0] value_q;
  logic              valid_q;
  psif_tok_t         tok_q;
  logic [IDX_W-1:0]  partner_q;
  logic              sel;
  logic              match;

  assign sel   = wr_i.en && (wr_idx_i == IDX_W'(INDEX));
  assign match = tok_i.active && valid_q && ({value_q[DATA_W-1], value_q} == comp_i);

  always_ff @(posedge clk_i) begin
    if (sel) begin
      value_q <= wr_data_i;
    end
  end

  // Clear wins over a store made by the last item of an array.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      if (wr_i.clr) begin
        valid_q <= 1'b0;
      end else if (sel) begin
        valid_q <= 1'b1;
      end
      tok_q.active <= tok_i.active;
      tok_q.hit    <= tok_i.hit | match;
    end
  end

  // Later cells override: the partner ends as the latest matching position.
  always_ff @(posedge clk_i) begin
    partner_q <= match ? IDX_W'(INDEX) : partner_i;
  end

  assign tok_o     = tok_q;
  assign partner_o = partner_q;

endmodule

### sv/pair_sum_index_finder.sv
// Top level of the pair sum index finder: control, result register and cell chain.
//
// Input stream: s_axis_tdata_i carries one signed 32-bit array element,
// s_axis_tlast_i marks the final element of an array. Output stream: one
// result per element, status in m_axis_tuser_o, indices in m_axis_tdata_o,
// m_axis_tlast_o echoes the last mark. target_sum is written through
// cfg_we_i / cfg_wdata_i; the user must do so only while the block is idle,
// which the block itself does not enforce. Each element forms target_sum -
// value in 33 bits and sends a search token down a chain of MAX_ENTRIES
// cells, one cell per cycle; the latest stored match wins. A searching
// element's result moves from the cell chain into the status and partner
// registers, then into the output register once it is free. An element after
// a find, or beyond the table capacity, skips the search. One element is in
// work at a time; the next request is accepted as soon as the previous result
// sits in the output register, even if the receiver stalls it. A stalled
// result holds; the following element waits in the done state until the
// output register frees up. Reset empties the table, zeroes the counters and
// sets target_sum to 0. The last element clears the table after its result.
module pair_sum_index_finder import psif_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [DATA_W-1:0]      cfg_wdata_i,     // target_sum
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [DATA_W-1:0]      s_axis_tdata_i,  // [31:0] value
  input  logic                   s_axis_tlast_i,  // last_item
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // [5:0] current_index, [11:6] partner_index
  output logic [1:0]             m_axis_tuser_o,  // [1:0] status
  output logic                   m_axis_tlast_o   // array_end
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  state_e                 state_q, state_d;
  logic [DATA_W-1:0]      target_q;
  logic [CNT_W-1:0]       count_q;
  logic                   found_q;
  logic [DATA_W-1:0]      val_q;
  logic                   last_q;
  status_e                status_q;
  logic [IDX_W-1:0]       partner_q;
  logic [CMP_W-1:0]       comp_q;
  logic                   start_q;
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [OUT_IDX_W-1:0]   out_cur_q;
  logic [OUT_IDX_W-1:0]   out_partner_q;
  logic                   out_last_q;

  logic                   accept;
  logic                   full;
  logic                   out_free;
  logic                   finish;
  logic [IDX_W-1:0]       shown;
  psif_wr_t               wr;

  psif_tok_t              tok   [MAX_ENTRIES+1];
  logic [IDX_W-1:0]       partn [MAX_ENTRIES+1];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign full     = (count_q == CNT_W'(MAX_ENTRIES));
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign finish   = (state_q == ST_DONE) && out_free;
  assign shown    = full ? IDX_W'(MAX_ENTRIES - 1) : count_q[IDX_W-1:0];

  assign wr.en  = finish && (status_q == STAT_STORED);
  assign wr.clr = finish && last_q;

  assign tok[0]   = '{active: start_q, hit: 1'b0};
  assign partn[0] = '0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    psif_cell #(
      .IDX_W (IDX_W),
      .INDEX (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[k]),
      .partner_i (partn[k]),
      .comp_i    (comp_q),
      .wr_i      (wr),
      .wr_idx_i  (count_q[IDX_W-1:0]),
      .wr_data_i (val_q),
      .tok_o     (tok[k+1]),
      .partner_o (partn[k+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (found_q || full) ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok[MAX_ENTRIES].active) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept && !found_q && !full;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      // Advance the counters on completion; the last item drops the array.
      if (finish) begin
        if (last_q) begin
          count_q <= '0;
          found_q <= 1'b0;
        end else begin
          if (!full) begin
            count_q <= count_q + CNT_W'(1);
          end
          if (status_q == STAT_FOUND) begin
            found_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q     <= s_axis_tdata_i;
      last_q    <= s_axis_tlast_i;
      partner_q <= '0;
      comp_q    <= {target_q[DATA_W-1], target_q} - {s_axis_tdata_i[DATA_W-1], s_axis_tdata_i};
      priority if (found_q) begin
        status_q <= STAT_IGNORED;
      end else if (full) begin
        status_q <= STAT_FULL;
      end else begin
        status_q <= STAT_STORED;
      end
    end else if (state_q == ST_SEARCH && tok[MAX_ENTRIES].active) begin
      status_q  <= tok[MAX_ENTRIES].hit ? STAT_FOUND : STAT_STORED;
      partner_q <= tok[MAX_ENTRIES].hit ? partn[MAX_ENTRIES] : '0;
    end
    if (finish) begin
      out_status_q  <= status_q;
      out_cur_q     <= OUT_IDX_W'(shown);
      out_partner_q <= OUT_IDX_W'(partner_q);
      out_last_q    <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 2 * OUT_IDX_W)'(0), out_partner_q, out_cur_q};
  assign m_axis_tlast_o  = out_last_q;

`include "pair_sum_index_finder_assert.svh"

  `PSIF_ASSERT(a_state_onehot, $onehot(state_q))
  `PSIF_ASSERT_IMP(a_token_in_search, tok[MAX_ENTRIES].active, state_q == ST_SEARCH)
  `PSIF_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ENTRIES))
  `PSIF_ASSERT_IMP(a_found_has_items, found_q, count_q != '0)

endmodule
